// ----- rtl/core/tadt_pkg.sv -----
package tadt_pkg;

    // Defaults and fixed field widths
    localparam int TILE_SIDE_DEF = 40;
    localparam int LEVELS        = 256;
    localparam int LEVEL_W       = 8;
    localparam int PIX_W         = 8;
    localparam int LIMIT_W       = 8;
    localparam int RATIO_W       = 10;
    localparam int FRAC_W        = 8;
    localparam int MEAN_W        = 2 * FRAC_W;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam logic [LIMIT_W-1:0] CONTRAST_RESET = 8'd48;
    localparam logic [RATIO_W-1:0] RATIO_RESET    = 10'd282;

    // Register index, taken from paddr[2]
    typedef enum logic
    {
        REG_CONTRAST = 1'b0,
        REG_RATIO    = 1'b1
    } reg_idx_t;

    // Input item opcode
    typedef enum logic
    {
        ACT_LOAD = 1'b0,
        ACT_EMIT = 1'b1
    } action_t;

    // Sequencer states, one-hot
    typedef enum logic [4:0]
    {
        ST_CLEAR = 5'b00001,
        ST_LOAD  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_FIN   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

endpackage

// ----- rtl/core/tile_adaptive_dark_threshold.sv -----
// Tile adaptive dark threshold.
// Input channel (in_valid/in_ready): action 0 loads one gray pixel of a
// TILE_SIDE x TILE_SIDE tile in raster order, action 1 asks for the next
// classified pixel. Output channel (out_valid/out_ready): one item per
// emit taken after a full load, carrying dark and last_of_tile.
// A load or an emit is not taken back to back: while the histogram
// read-modify-write of a load or the tile store read of an emit is pending,
// in_ready is low. Emits in the load phase and loads in the emit phase are
// taken at one per cycle (in the emit phase only while the output buffer is
// not full) and dropped. The result of an emit is first registered as
// pending, then moves into the output register, or into the hold register
// when the output register is busy. After the last load the block walks all
// 256 histogram entries, clearing them as it goes, then runs the band compare
// and the 16-step mean divider; in_ready is low meanwhile. After reset a
// clearing pass writes zero to the 256 histogram entries with in_ready low; the APB port works throughout.
// A two-entry output buffer lets one further emit be taken while a result
// waits; with both entries full, in_ready drops until out_ready returns.
module tile_adaptive_dark_threshold
    import tadt_pkg::*;
#(
    parameter int TILE_SIDE = TILE_SIDE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  action,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  dark,
    output logic                  last_of_tile,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int N        = TILE_SIDE * TILE_SIDE;
    localparam int IDX_W    = $clog2(N + 1);
    localparam int ADDR_W   = $clog2(N);
    localparam int CNT_W    = $clog2(N + 1);
    localparam int SUM_W    = $clog2(255 * N + 1);
    localparam int EDGE_W   = $clog2(510 * N + 1);
    localparam int PROD_W   = SUM_W + CNT_W;
    localparam int LIM_W    = LIMIT_W + 2 * CNT_W;
    localparam int CMP_W    = ((PROD_W > LIM_W) ? PROD_W : LIM_W) + 1;
    localparam int ZPROD_W  = LEVEL_W + CNT_W;
    localparam int DCNT_W   = $clog2(MEAN_W);
    localparam int THR_W    = MEAN_W + RATIO_W;

    localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(N - 1);
    localparam logic [EDGE_W-1:0] N_E        = EDGE_W'(N);
    localparam logic [EDGE_W-1:0] TWO_N_E    = EDGE_W'(2 * N);
    localparam logic [DCNT_W-1:0] DIV_LAST   = DCNT_W'(MEAN_W - 1);

    // Memories
    logic [PIX_W-1:0] store_mem [N];
    logic [CNT_W-1:0] hist_mem [LEVELS];

    logic               store_we;
    logic [ADDR_W-1:0]  store_wa;
    logic [ADDR_W-1:0]  store_ra;
    logic [PIX_W-1:0]   store_rd_reg;
    logic               hist_we;
    logic [LEVEL_W-1:0] hist_wa;
    logic [CNT_W-1:0]   hist_wd;
    logic [LEVEL_W-1:0] hist_ra;
    logic [CNT_W-1:0]   hist_rd_reg;

    // Control state
    state_t               state_reg, state_next;
    logic [LEVEL_W-1:0]   clear_idx_reg, clear_idx_next;
    logic [LEVEL_W:0]     walk_z_reg, walk_z_next;
    logic [IDX_W-1:0]     load_index_reg, load_index_next;
    logic [IDX_W-1:0]     emit_index_reg, emit_index_next;
    logic [PIX_W-1:0]     min_reg, min_next;
    logic [PIX_W-1:0]     max_reg, max_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic                 pend_load_reg, pend_load_next;
    logic                 pend_last_reg, pend_last_next;
    logic                 pend_emit_reg, pend_emit_next;
    logic                 pend_elast_reg, pend_elast_next;
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s2_valid_reg, s2_valid_next;
    logic [1:0]           fin_step_reg, fin_step_next;
    logic                 div_run_reg, div_run_next;
    logic [DCNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [MEAN_W-1:0]    mean_reg, mean_next;
    logic                 flat_reg, flat_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 hold_valid_reg, hold_valid_next;
    logic [LIMIT_W-1:0]   contrast_reg, contrast_next;
    logic [RATIO_W-1:0]   ratio_reg, ratio_next;

    // Datapath registers
    logic [PIX_W-1:0]     pend_pix_reg, pend_pix_next;
    logic [LIMIT_W-1:0]   lim_latch_reg, lim_latch_next;
    logic [EDGE_W-1:0]    low_edge_reg, high_edge_reg;
    logic [LEVEL_W-1:0]   s1_z_reg, s1_z_next;
    logic [SUM_W-1:0]     s2_prod_reg, s2_prod_next;
    logic [CNT_W-1:0]     s2_cnt_reg, s2_cnt_next;
    logic                 s2_lo_reg, s2_lo_next;
    logic                 s2_hi_reg, s2_hi_next;
    logic [SUM_W-1:0]     lo_t_reg, lo_t_next;
    logic [SUM_W-1:0]     hi_t_reg, hi_t_next;
    logic [CNT_W-1:0]     lo_c_reg, lo_c_next;
    logic [CNT_W-1:0]     hi_c_reg, hi_c_next;
    logic [PROD_W-1:0]    p1_reg, p1_next;
    logic [PROD_W-1:0]    p2_reg, p2_next;
    logic [LIMIT_W+CNT_W-1:0] p3_reg, p3_next;
    logic [LIM_W-1:0]     p4_reg, p4_next;
    logic [CNT_W-1:0]     div_rem_reg, div_rem_next;
    logic [MEAN_W-1:0]    div_sh_reg, div_sh_next;
    logic [MEAN_W-1:0]    div_q_reg, div_q_next;
    logic                 out_dark_reg, out_dark_next;
    logic                 out_last_reg, out_last_next;
    logic                 hold_dark_reg, hold_dark_next;
    logic                 hold_last_reg, hold_last_next;

    // Combinational helpers
    logic                 in_fire;
    logic                 cfg_wr;
    logic [EDGE_W-1:0]    z2n;
    logic [ZPROD_W-1:0]   zprod;
    logic [CNT_W:0]       div_trial;
    logic [THR_W-1:0]     thr;
    logic [THR_W-1:0]     pix_scaled;
    logic                 dark_calc;
    logic                 take;

    // Handshakes
    assign in_ready = !pend_load_reg && !pend_emit_reg &&
                      ((state_reg == ST_LOAD) ||
                       ((state_reg == ST_EMIT) && !hold_valid_reg));
    assign in_fire  = in_valid && in_ready;
    assign take     = out_valid_reg && out_ready;

    assign out_valid    = out_valid_reg;
    assign dark         = out_dark_reg;
    assign last_of_tile = out_last_reg;

    // APB register port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        case (reg_idx_t'(paddr[2]))
            REG_CONTRAST: prdata = APB_DATA_W'(contrast_reg);
            REG_RATIO:    prdata = APB_DATA_W'(ratio_reg);
            default:      prdata = '0;
        endcase
    end

    always_comb
    begin
        contrast_next = contrast_reg;
        ratio_next    = ratio_reg;
        if (cfg_wr)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_CONTRAST: contrast_next = pwdata[LIMIT_W-1:0];
                REG_RATIO:    ratio_next    = pwdata[RATIO_W-1:0];
                default:      contrast_next = contrast_reg;
            endcase
        end
    end

    // Walk stage 1 terms: level position against the band edges, weighted count; divider trial value
    assign z2n       = EDGE_W'(s1_z_reg) * TWO_N_E;
    assign zprod     = s1_z_reg * hist_rd_reg;
    assign div_trial = {div_rem_reg, div_sh_reg[MEAN_W-1]};

    // Emit classification
    assign thr        = mean_reg * ratio_reg;
    assign pix_scaled = THR_W'({store_rd_reg, {MEAN_W{1'b0}}});
    assign dark_calc  = !flat_reg && (pix_scaled <= thr);

    // Sequencer and datapath next state
    always_comb
    begin
        state_next      = state_reg;
        clear_idx_next  = clear_idx_reg;
        walk_z_next     = walk_z_reg;
        load_index_next = load_index_reg;
        emit_index_next = emit_index_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        sum_next        = sum_reg;
        pend_load_next  = 1'b0;
        pend_last_next  = 1'b0;
        pend_emit_next  = 1'b0;
        pend_elast_next = 1'b0;
        pend_pix_next   = pend_pix_reg;
        lim_latch_next  = lim_latch_reg;
        s1_valid_next   = 1'b0;
        s1_z_next       = s1_z_reg;
        s2_valid_next   = 1'b0;
        s2_prod_next    = s2_prod_reg;
        s2_cnt_next     = s2_cnt_reg;
        s2_lo_next      = s2_lo_reg;
        s2_hi_next      = s2_hi_reg;
        lo_t_next       = lo_t_reg;
        hi_t_next       = hi_t_reg;
        lo_c_next       = lo_c_reg;
        hi_c_next       = hi_c_reg;
        fin_step_next   = fin_step_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        p3_next         = p3_reg;
        p4_next         = p4_reg;
        div_run_next    = div_run_reg;
        div_cnt_next    = div_cnt_reg;
        div_rem_next    = div_rem_reg;
        div_sh_next     = div_sh_reg;
        div_q_next      = div_q_reg;
        mean_next       = mean_reg;
        flat_next       = flat_reg;

        store_we = 1'b0;
        store_wa = load_index_reg[ADDR_W-1:0];
        store_ra = emit_index_reg[ADDR_W-1:0];
        hist_we  = 1'b0;
        hist_wa  = pend_pix_reg;
        hist_wd  = hist_rd_reg + CNT_W'(1);
        hist_ra  = walk_z_reg[LEVEL_W-1:0];

        // Pending load: write back the incremented count; after the last load, start the walk
        if (pend_load_reg)
        begin
            hist_we = 1'b1;
            if (pend_last_reg)
            begin
                state_next  = ST_WALK;
                walk_z_next = '0;
                lo_t_next   = '0;
                hi_t_next   = '0;
                lo_c_next   = '0;
                hi_c_next   = '0;
            end
        end

        // Iterative divider for the low band mean
        if (div_run_reg)
        begin
            if (div_trial >= {1'b0, lo_c_reg})
            begin
                div_rem_next = CNT_W'(div_trial - {1'b0, lo_c_reg});
                div_q_next   = {div_q_reg[MEAN_W-2:0], 1'b1};
            end
            else
            begin
                div_rem_next = div_trial[CNT_W-1:0];
                div_q_next   = {div_q_reg[MEAN_W-2:0], 1'b0};
            end
            div_sh_next  = {div_sh_reg[MEAN_W-2:0], 1'b0};
            div_cnt_next = div_cnt_reg + DCNT_W'(1);
            if (div_cnt_reg == DIV_LAST)
            begin
                div_run_next = 1'b0;
            end
        end

        case (state_reg)
            ST_CLEAR:
            begin
                hist_we        = 1'b1;
                hist_wa        = clear_idx_reg;
                hist_wd        = '0;
                clear_idx_next = clear_idx_reg + LEVEL_W'(1);
                if (clear_idx_reg == LEVEL_W'(LEVELS - 1))
                begin
                    state_next = ST_LOAD;
                end
            end

            ST_LOAD:
            begin
                if (in_fire && (action == ACT_LOAD))
                begin
                    store_we        = 1'b1;
                    hist_ra         = pixel;
                    pend_load_next  = 1'b1;
                    pend_pix_next   = pixel;
                    load_index_next = load_index_reg + IDX_W'(1);
                    sum_next        = sum_reg + SUM_W'(pixel);
                    if (pixel < min_reg)
                    begin
                        min_next = pixel;
                    end
                    if (pixel > max_reg)
                    begin
                        max_next = pixel;
                    end
                    if (load_index_reg == LAST_IDX)
                    begin
                        pend_last_next = 1'b1;
                        lim_latch_next = contrast_reg;
                    end
                end
            end

            ST_WALK:
            begin
                // issue reads, one level per cycle
                if (!walk_z_reg[LEVEL_W])
                begin
                    s1_valid_next = 1'b1;
                    s1_z_next     = walk_z_reg[LEVEL_W-1:0];
                    walk_z_next   = walk_z_reg + (LEVEL_W + 1)'(1);
                end
                // count arrives: clear the entry, classify the level
                if (s1_valid_reg)
                begin
                    hist_we       = 1'b1;
                    hist_wa       = s1_z_reg;
                    hist_wd       = '0;
                    s2_valid_next = 1'b1;
                    s2_prod_next  = SUM_W'(zprod);
                    s2_cnt_next   = hist_rd_reg;
                    s2_lo_next    = (z2n <= low_edge_reg);
                    s2_hi_next    = (z2n >= high_edge_reg);
                end
                // accumulate band totals and counts
                if (s2_valid_reg)
                begin
                    if (s2_lo_reg)
                    begin
                        lo_t_next = lo_t_reg + s2_prod_reg;
                        lo_c_next = lo_c_reg + s2_cnt_reg;
                    end
                    if (s2_hi_reg)
                    begin
                        hi_t_next = hi_t_reg + s2_prod_reg;
                        hi_c_next = hi_c_reg + s2_cnt_reg;
                    end
                end
                if (walk_z_reg[LEVEL_W] && !s1_valid_reg && !s2_valid_reg)
                begin
                    state_next    = ST_FIN;
                    fin_step_next = '0;
                end
            end

            ST_FIN:
            begin
                case (fin_step_reg)
                    2'd0:
                    begin
                        if ((lo_c_reg == '0) || (hi_c_reg == '0))
                        begin
                            flat_next  = 1'b1;
                            mean_next  = '0;
                            state_next = ST_EMIT;
                        end
                        else
                        begin
                            p1_next       = hi_t_reg * lo_c_reg;
                            p2_next       = lo_t_reg * hi_c_reg;
                            p3_next       = lim_latch_reg * hi_c_reg;
                            div_run_next  = 1'b1;
                            div_cnt_next  = '0;
                            div_rem_next  = CNT_W'(lo_t_reg >> FRAC_W);
                            div_sh_next   = {lo_t_reg[FRAC_W-1:0], {FRAC_W{1'b0}}};
                            div_q_next    = '0;
                            fin_step_next = 2'd1;
                        end
                    end
                    2'd1:
                    begin
                        p4_next       = p3_reg * lo_c_reg;
                        fin_step_next = 2'd2;
                    end
                    2'd2:
                    begin
                        flat_next     = (CMP_W'(p1_reg) <= (CMP_W'(p2_reg) + CMP_W'(p4_reg)));
                        fin_step_next = 2'd3;
                    end
                    default:
                    begin
                        if (!div_run_reg)
                        begin
                            mean_next  = div_q_reg;
                            state_next = ST_EMIT;
                        end
                    end
                endcase
            end

            ST_EMIT:
            begin
                if (in_fire && (action == ACT_EMIT))
                begin
                    pend_emit_next  = 1'b1;
                    emit_index_next = emit_index_reg + IDX_W'(1);
                    if (emit_index_reg == LAST_IDX)
                    begin
                        // end of tile: back to an empty tile
                        pend_elast_next = 1'b1;
                        min_next        = {PIX_W{1'b1}};
                        max_next        = '0;
                        sum_next        = '0;
                        load_index_next = '0;
                        emit_index_next = '0;
                        state_next      = ST_LOAD;
                    end
                end
            end

            default:
            begin
                state_next     = ST_CLEAR;
                clear_idx_next = '0;
            end
        endcase
    end

    // Two-entry output buffer: out register plus a hold register behind it
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_dark_next   = out_dark_reg;
        out_last_next   = out_last_reg;
        hold_valid_next = hold_valid_reg;
        hold_dark_next  = hold_dark_reg;
        hold_last_next  = hold_last_reg;
        if (!out_valid_reg || take)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_dark_next   = hold_dark_reg;
                out_last_next   = hold_last_reg;
                hold_valid_next = pend_emit_reg;
                hold_dark_next  = dark_calc;
                hold_last_next  = pend_elast_reg;
            end
            else
            begin
                out_valid_next = pend_emit_reg;
                out_dark_next  = dark_calc;
                out_last_next  = pend_elast_reg;
            end
        end
        else if (pend_emit_reg)
        begin
            hold_valid_next = 1'b1;
            hold_dark_next  = dark_calc;
            hold_last_next  = pend_elast_reg;
        end
    end

    // Tile store
    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[store_wa] <= pixel;
        end
        store_rd_reg <= store_mem[store_ra];
    end

    // Level histogram
    always_ff @(posedge clk)
    begin
        if (hist_we)
        begin
            hist_mem[hist_wa] <= hist_wd;
        end
        hist_rd_reg <= hist_mem[hist_ra];
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clear_idx_reg  <= '0;
            walk_z_reg     <= '0;
            load_index_reg <= '0;
            emit_index_reg <= '0;
            min_reg        <= {PIX_W{1'b1}};
            max_reg        <= '0;
            sum_reg        <= '0;
            pend_load_reg  <= 1'b0;
            pend_last_reg  <= 1'b0;
            pend_emit_reg  <= 1'b0;
            pend_elast_reg <= 1'b0;
            s1_valid_reg   <= 1'b0;
            s2_valid_reg   <= 1'b0;
            fin_step_reg   <= '0;
            div_run_reg    <= 1'b0;
            div_cnt_reg    <= '0;
            mean_reg       <= '0;
            flat_reg       <= 1'b1;
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
            contrast_reg   <= CONTRAST_RESET;
            ratio_reg      <= RATIO_RESET;
        end
        else
        begin
            state_reg      <= state_next;
            clear_idx_reg  <= clear_idx_next;
            walk_z_reg     <= walk_z_next;
            load_index_reg <= load_index_next;
            emit_index_reg <= emit_index_next;
            min_reg        <= min_next;
            max_reg        <= max_next;
            sum_reg        <= sum_next;
            pend_load_reg  <= pend_load_next;
            pend_last_reg  <= pend_last_next;
            pend_emit_reg  <= pend_emit_next;
            pend_elast_reg <= pend_elast_next;
            s1_valid_reg   <= s1_valid_next;
            s2_valid_reg   <= s2_valid_next;
            fin_step_reg   <= fin_step_next;
            div_run_reg    <= div_run_next;
            div_cnt_reg    <= div_cnt_next;
            mean_reg       <= mean_next;
            flat_reg       <= flat_next;
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
            contrast_reg   <= contrast_next;
            ratio_reg      <= ratio_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        pend_pix_reg  <= pend_pix_next;
        lim_latch_reg <= lim_latch_next;
        low_edge_reg  <= EDGE_W'(min_reg) * N_E + EDGE_W'(sum_reg);
        high_edge_reg <= EDGE_W'(max_reg) * N_E + EDGE_W'(sum_reg);
        s1_z_reg      <= s1_z_next;
        s2_prod_reg   <= s2_prod_next;
        s2_cnt_reg    <= s2_cnt_next;
        s2_lo_reg     <= s2_lo_next;
        s2_hi_reg     <= s2_hi_next;
        lo_t_reg      <= lo_t_next;
        hi_t_reg      <= hi_t_next;
        lo_c_reg      <= lo_c_next;
        hi_c_reg      <= hi_c_next;
        p1_reg        <= p1_next;
        p2_reg        <= p2_next;
        p3_reg        <= p3_next;
        p4_reg        <= p4_next;
        div_rem_reg   <= div_rem_next;
        div_sh_reg    <= div_sh_next;
        div_q_reg     <= div_q_next;
        out_dark_reg  <= out_dark_next;
        out_last_reg  <= out_last_next;
        hold_dark_reg <= hold_dark_next;
        hold_last_reg <= hold_last_next;
    end

endmodule
